// File: sv/pbfc_pkg.sv
// Shared types, widths and command codes of the partitioned Bloom filter counter.
`default_nettype none
package pbfc_pkg;

  localparam int CMD_W       = 2;
  localparam int HASH_W      = 12;
  localparam int HASH_FIELDS = 4;
  localparam int HIT_W       = 3;
  localparam int TOTAL_W     = 15;
  localparam int TOTAL_MAX   = 32767;
  localparam int RECIP_SHIFT = 24;

  localparam int NUM_HASHES_DEF = 4;
  localparam int HASH_RANGE_DEF = 4096;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [HASH_W-1:0] hash_0;
    logic [HASH_W-1:0] hash_1;
    logic [HASH_W-1:0] hash_2;
    logic [HASH_W-1:0] hash_3;
  } in_word_t;

  typedef struct packed {
    logic [HIT_W-1:0]   hit_count;
    logic [TOTAL_W-1:0] ones_total;
  } out_word_t;

  typedef struct packed {
    logic load_q;
    logic load_r;
  } pipe_en_t;

endpackage
`default_nettype wire

// File: sv/pbfc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pbfc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: sv/pbfc_index.sv
// Two-stage reduction of one hash field modulo the partition size.
`default_nettype none
module pbfc_index #(
  parameter int HASH_RANGE = pbfc_pkg::HASH_RANGE_DEF
) (
  input  wire logic                            clk,
  input  wire pbfc_pkg::pipe_en_t              en,
  input  wire logic [pbfc_pkg::HASH_W-1:0]     hash,
  output logic      [$clog2(HASH_RANGE)-1:0]   idx
);

  localparam int HW    = pbfc_pkg::HASH_W;
  localparam int MW    = pbfc_pkg::RECIP_SHIFT;
  localparam int PW    = HW + MW;
  localparam int RW    = $clog2(HASH_RANGE + 1);
  localparam int DW    = HW + RW;
  localparam int IDX_W = $clog2(HASH_RANGE);
  localparam longint RECIP = (64'd1 << MW) / HASH_RANGE;

  logic [PW-1:0]    prod;
  logic [HW-1:0]    q_r;
  logic [HW-1:0]    h_r;
  logic [DW-1:0]    qr;
  logic [DW-1:0]    rem_est;
  logic [DW-1:0]    rem;
  logic [IDX_W-1:0] idx_r;

  assign prod = PW'(hash) * PW'(RECIP);

  always_ff @(posedge clk) begin
    if (en.load_q) begin
      q_r <= prod[PW-1:MW];
      h_r <= hash;
    end
  end

  assign qr      = DW'(q_r) * DW'(HASH_RANGE);
  assign rem_est = DW'(h_r) - qr;
  assign rem     = (rem_est >= DW'(HASH_RANGE)) ? rem_est - DW'(HASH_RANGE) : rem_est;

  always_ff @(posedge clk) begin
    if (en.load_r) begin
      idx_r <= rem[IDX_W-1:0];
    end
  end

  assign idx = idx_r;

endmodule
`default_nettype wire

// File: sv/partitioned_bloom_filter_counter_top.sv
// Partitioned Bloom filter with collision count and running set-bit total.
// Input channel in_valid/in_stall/in_data carries a command and one hash index
// per partition; each accepted word yields exactly one result word on
// out_valid/out_stall/out_data. Insert sets the addressed bit in every used
// partition and raises the total by the bits newly set; query returns how many
// addressed bits are already set; read (and the unused code) returns the total.
// An accepted word passes through registered stages in order (index
// reduction, reduction correction and RAM address, RAM read with forwarding,
// output register) before its result shows on out_valid.
// Throughput: one word per cycle while out_stall is low; each partition is
// its own one-bit RAM with one read and one write port, and the write of the
// previous word is forwarded to the read of the next.
// Reset: rst_n clears control state and starts a clearing pass over every
// address that zeroes all partitions; in_stall stays high during the pass.
// A stalled receiver holds the output register; the stages behind it keep
// filling until every stage holds a word, then in_stall rises.
`default_nettype none
module partitioned_bloom_filter_counter_top #(
  parameter int NUM_HASHES = pbfc_pkg::NUM_HASHES_DEF,
  parameter int HASH_RANGE = pbfc_pkg::HASH_RANGE_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire pbfc_pkg::in_word_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output pbfc_pkg::out_word_t      out_data
);

  localparam int USED    = (NUM_HASHES < pbfc_pkg::HASH_FIELDS) ?
                           NUM_HASHES : pbfc_pkg::HASH_FIELDS;
  localparam int IDX_W   = $clog2(HASH_RANGE);
  localparam int CMD_W   = pbfc_pkg::CMD_W;
  localparam int HIT_W   = pbfc_pkg::HIT_W;
  localparam int TOTAL_W = pbfc_pkg::TOTAL_W;

  logic [pbfc_pkg::HASH_W-1:0] hash_in [pbfc_pkg::HASH_FIELDS];

  logic               clr_r, clr_nxt;
  logic [IDX_W-1:0]   clr_addr_r, clr_addr_nxt;
  logic               v1_r, v2_r, v3_r;
  logic [CMD_W-1:0]   cmd1_r, cmd2_r, cmd3_r;
  logic               adv_out, adv3, adv2, adv1;
  logic               fire3, wr_en;
  pbfc_pkg::pipe_en_t pipe_en;

  logic [IDX_W-1:0]   idx2      [USED];
  logic [IDX_W-1:0]   idx3_r    [USED];
  logic [IDX_W-1:0]   fwd_idx_r [USED];
  logic               fwd_v_r;
  logic [USED-1:0]    rdata;
  logic [USED-1:0]    bit_s3;

  logic [HIT_W-1:0]   hits;
  logic [HIT_W-1:0]   newly;
  logic [TOTAL_W:0]   sum;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic               out_v_r;
  pbfc_pkg::out_word_t out_data_r, out_data_nxt;

  assign hash_in[0] = in_data.hash_0;
  assign hash_in[1] = in_data.hash_1;
  assign hash_in[2] = in_data.hash_2;
  assign hash_in[3] = in_data.hash_3;

  assign adv_out  = !out_v_r || !out_stall;
  assign adv3     = !v3_r || adv_out;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_stall = clr_r || !adv1;
  assign fire3    = v3_r && adv_out;
  assign wr_en    = fire3 && (cmd3_r == pbfc_pkg::CMD_INSERT);

  assign pipe_en.load_q = adv1;
  assign pipe_en.load_r = adv2;

  always_comb begin
    clr_nxt      = clr_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_r) begin
      clr_addr_nxt = clr_addr_r + IDX_W'(1);
      if (clr_addr_r == IDX_W'(HASH_RANGE - 1)) begin
        clr_nxt = 1'b0;
      end
    end
  end

  genvar p;
  generate
    for (p = 0; p < USED; p++) begin : g_part
      logic [IDX_W-1:0] waddr;

      pbfc_index #(
        .HASH_RANGE(HASH_RANGE)
      ) u_index (
        .clk (clk),
        .en  (pipe_en),
        .hash(hash_in[p]),
        .idx (idx2[p])
      );

      assign waddr = clr_r ? clr_addr_r : idx3_r[p];

      pbfc_ram #(
        .WIDTH(1),
        .DEPTH(HASH_RANGE)
      ) u_ram (
        .clk  (clk),
        .we   (clr_r || wr_en),
        .waddr(waddr),
        .wdata(!clr_r),
        .re   (adv3),
        .raddr(idx2[p]),
        .rdata(rdata[p])
      );

      assign bit_s3[p] = rdata[p] || (fwd_v_r && (fwd_idx_r[p] == idx3_r[p]));

      always_ff @(posedge clk) begin
        if (adv3) begin
          idx3_r[p] <= idx2[p];
        end
        if (wr_en) begin
          fwd_idx_r[p] <= idx3_r[p];
        end
      end
    end
  endgenerate

  always_comb begin
    hits  = '0;
    newly = '0;
    for (int i = 0; i < USED; i++) begin
      hits  = hits + HIT_W'(bit_s3[i]);
      newly = newly + HIT_W'(!bit_s3[i]);
    end
  end

  always_comb begin
    sum       = (TOTAL_W + 1)'(total_r) + (TOTAL_W + 1)'(newly);
    total_nxt = total_r;
    if (cmd3_r == pbfc_pkg::CMD_INSERT) begin
      total_nxt = (sum > (TOTAL_W + 1)'(pbfc_pkg::TOTAL_MAX)) ?
                  TOTAL_W'(pbfc_pkg::TOTAL_MAX) : sum[TOTAL_W-1:0];
    end
    out_data_nxt.ones_total = total_nxt;
    out_data_nxt.hit_count  = (cmd3_r == pbfc_pkg::CMD_QUERY) ? hits : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      v3_r       <= 1'b0;
      fwd_v_r    <= 1'b0;
      total_r    <= '0;
      out_v_r    <= 1'b0;
    end else begin
      clr_r      <= clr_nxt;
      clr_addr_r <= clr_addr_nxt;
      if (adv1) begin
        v1_r <= in_valid && !clr_r;
      end
      if (adv2) begin
        v2_r <= v1_r;
      end
      if (adv3) begin
        v3_r <= v2_r;
      end
      if (wr_en) begin
        fwd_v_r <= 1'b1;
      end
      if (fire3) begin
        total_r <= total_nxt;
      end
      if (adv_out) begin
        out_v_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      cmd1_r <= in_data.cmd;
    end
    if (adv2) begin
      cmd2_r <= cmd1_r;
    end
    if (adv3) begin
      cmd3_r <= cmd2_r;
    end
    if (adv_out) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> !(v1_r || v2_r || v3_r || out_v_r))
    else $error("word in flight during clearing pass");

  a_total_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> total_r >= $past(total_r))
    else $error("running total decreased");

  a_hit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> out_data_r.hit_count <= HIT_W'(USED))
    else $error("hit count exceeds partition count");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !clr_r && v3_r)
    else $error("partition write without a word in the last stage");

endmodule
`default_nettype wire
